// ----- hdl/i2c_master_byte_engine_unit_macros.svh -----
// assertion macros for the i2c master byte engine
// used by the top level only, expects clk and rst_n in scope
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2cm_pkg.sv -----
// shared types and constants for the i2c master byte engine
// no dependencies
`default_nettype none

package i2cm_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned QT_W     = 16;
    localparam int unsigned ADDR_W   = 3;

    // action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd4;

    localparam logic [QT_W-1:0] QUARTER_TICKS_RESET = 16'd30;

    // register index, taken from paddr[2]
    localparam logic REG_QUARTER_TICKS = 1'b0;

    // bit index at which the acknowledge bit runs
    localparam logic [3:0] ACK_BIT = 4'd8;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_START = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_READ  = 3'd3,
        MODE_STOP  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   tx_byte;
        logic                send_ack;
        logic                sda_in;
    } in_word_t;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic              ack_received;
        logic [BYTE_W-1:0] rx_byte;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/i2cm_in_if.sv -----
// input channel: one tick word with command and sampled sda
// depends on nothing
`default_nettype none

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, action, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, action, tx_byte, send_ack, sda_in, output ready);
endinterface

`default_nettype wire

// ----- hdl/i2cm_out_if.sv -----
// output channel: one result word per tick
// depends on nothing
`default_nettype none

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] rx_byte;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, ack_received,
                    rx_byte, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, ack_received,
                    rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/i2c_master_byte_engine_unit.sv -----
// I2C master byte engine, stepped by one input word per clock tick.
// One word is taken every cycle; its result word is registered and offered on the
// output channel once earlier words have gone. The next state of the sequencer is
// worked out in a single pass from the state registers and the word, so the rate
// is set by the handshake alone: in_ch.ready falls only when the result register
// and its skid entry both hold words not yet taken. quarter_ticks is written over
// APB at byte addresses 0-3 and counts ticks per quarter bit, zero acting as one.
// depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_apb, i2cm_core, i2cm_out_buf
`default_nettype none
`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_master_byte_engine_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    i2cm_in_if.sink                          in_ch,
    i2cm_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import i2cm_pkg::*;

    in_word_t        word_in;
    result_t         core_result;
    result_t         out_word;
    logic [QT_W-1:0] quarter_ticks;
    logic            buf_ready;
    logic            step;

    assign word_in.action   = in_ch.action;
    assign word_in.tx_byte  = in_ch.tx_byte;
    assign word_in.send_ack = in_ch.send_ack;
    assign word_in.sda_in   = in_ch.sda_in;

    assign in_ch.ready = buf_ready;
    assign step        = in_ch.valid && buf_ready;

    i2cm_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .quarter_ticks (quarter_ticks)
    );

    i2cm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .word_in       (word_in),
        .quarter_ticks (quarter_ticks),
        .result        (core_result)
    );

    i2cm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_ch.valid),
        .push_ready (buf_ready),
        .push_data  (core_result),
        .pop_valid  (out_ch.valid),
        .pop_ready  (out_ch.ready),
        .pop_data   (out_word)
    );

    assign out_ch.scl_out      = out_word.scl_out;
    assign out_ch.sda_out      = out_word.sda_out;
    assign out_ch.busy_res     = out_word.busy_res;
    assign out_ch.done_res     = out_word.done_res;
    assign out_ch.ack_received = out_word.ack_received;
    assign out_ch.rx_byte      = out_word.rx_byte;

    // a finishing word never reports busy
    `I2CM_ASSERT_NOW(a_done_not_busy, out_ch.valid && out_ch.done_res, !out_ch.busy_res,
        "done word reports busy")

    // back-pressure only when a result is waiting
    `I2CM_ASSERT_NOW(a_stall_has_word, !in_ch.ready, out_ch.valid,
        "input stalled with no result waiting")

    // register write lands and reads back
    `I2CM_ASSERT_NEXT(a_cfg_readback,
        psel && penable && pwrite && (paddr == 3'd0),
        (paddr != 3'd0) || (prdata[15:0] == $past(pwdata[15:0])),
        "quarter_ticks readback mismatch")

endmodule

`default_nettype wire

// ----- hdl/i2cm_apb.sv -----
// apb configuration register: quarter_ticks
// depends on i2cm_pkg
`default_nettype none

module i2cm_apb (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [i2cm_pkg::QT_W-1:0] quarter_ticks
);
    import i2cm_pkg::*;

    logic [QT_W-1:0] qt_reg;
    logic [QT_W-1:0] qt_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        qt_next = qt_reg;
        if (wr_en && (paddr[2] == REG_QUARTER_TICKS))
        begin
            qt_next = pwdata[QT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qt_reg <= QUARTER_TICKS_RESET;
        end
        else
        begin
            qt_reg <= qt_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_QUARTER_TICKS)
        begin
            prdata = {{(32-QT_W){1'b0}}, qt_reg};
        end
    end

    assign quarter_ticks = qt_reg;

endmodule

`default_nettype wire

// ----- hdl/i2cm_core.sv -----
// bus sequencer: state registers and the one-tick next-state logic
// depends on i2cm_pkg
`default_nettype none

module i2cm_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire i2cm_pkg::in_word_t        word_in,
    input  wire logic [i2cm_pkg::QT_W-1:0] quarter_ticks,
    output i2cm_pkg::result_t              result
);
    import i2cm_pkg::*;

    mode_t             mode_reg,     mode_next;
    logic [1:0]        quarter_reg,  quarter_next;
    logic [3:0]        bit_reg,      bit_next;
    logic [BYTE_W-1:0] shift_reg,    shift_next;
    logic [QT_W-1:0]   div_reg,      div_next;
    logic              scl_reg,      scl_next;
    logic              sda_reg,      sda_next;
    logic              ack_reg,      ack_next;
    logic              send_ack_reg, send_ack_next;
    logic [BYTE_W-1:0] rx_reg,       rx_next;
    logic              done_next;
    logic [QT_W:0]     div_inc;
    logic              finished;

    // next state for one tick
    always_comb
    begin
        mode_next     = mode_reg;
        quarter_next  = quarter_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        div_next      = div_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_next      = ack_reg;
        send_ack_next = send_ack_reg;
        rx_next       = rx_reg;
        done_next     = 1'b0;
        finished      = 1'b0;
        div_inc       = '0;

        // command pickup, only while idle
        if ((mode_reg == MODE_IDLE) && (word_in.action inside
            {ACT_START, ACT_WRITE, ACT_READ, ACT_STOP}))
        begin
            quarter_next = 2'd0;
            bit_next     = 4'd0;
            div_next     = '0;
            case (word_in.action)
                ACT_START: mode_next = MODE_START;
                ACT_WRITE:
                begin
                    mode_next  = MODE_WRITE;
                    shift_next = word_in.tx_byte;
                end
                ACT_READ:
                begin
                    mode_next     = MODE_READ;
                    shift_next    = '0;
                    send_ack_next = word_in.send_ack;
                end
                ACT_STOP: mode_next = MODE_STOP;
                default: mode_next = MODE_IDLE;
            endcase
        end

        if (mode_next != MODE_IDLE)
        begin
            // action opening a quarter
            if (div_next == '0)
            begin
                case (mode_next)
                    MODE_START:
                    begin
                        case (quarter_next)
                            2'd0: sda_next = 1'b1;
                            2'd1: scl_next = 1'b1;
                            2'd2: sda_next = 1'b0;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    MODE_STOP:
                    begin
                        case (quarter_next)
                            2'd0: scl_next = 1'b0;
                            2'd1: sda_next = 1'b0;
                            2'd2: scl_next = 1'b1;
                            default: ;
                        endcase
                    end
                    MODE_WRITE:
                    begin
                        if (bit_next < ACK_BIT)
                        begin
                            case (quarter_next)
                                2'd1:
                                begin
                                    sda_next   = shift_next[BYTE_W-1];
                                    shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                                end
                                2'd2: scl_next = 1'b1;
                                2'd3: scl_next = 1'b0;
                                default: ;
                            endcase
                        end
                        else
                        begin
                            case (quarter_next)
                                2'd0: sda_next = 1'b1;
                                2'd1: scl_next = 1'b1;
                                2'd3:
                                begin
                                    ack_next = !word_in.sda_in;
                                    scl_next = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end
                    MODE_READ:
                    begin
                        if (bit_next < ACK_BIT)
                        begin
                            case (quarter_next)
                                2'd1: scl_next = 1'b1;
                                2'd3:
                                begin
                                    shift_next = {shift_next[BYTE_W-2:0], word_in.sda_in};
                                    scl_next   = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                        else
                        begin
                            case (quarter_next)
                                2'd1: sda_next = !send_ack_next;
                                2'd2: scl_next = 1'b1;
                                2'd3: scl_next = 1'b0;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end

            // a zero quarter length acts as one tick
            div_inc = {1'b0, div_next} + {{QT_W{1'b0}}, 1'b1};
            if (div_inc >= {1'b0, quarter_ticks})
            begin
                div_next = '0;
                if ((mode_next == MODE_STOP) && (quarter_next == 2'd2))
                begin
                    sda_next = 1'b1;
                    finished = 1'b1;
                end
                else if (quarter_next != 2'd3)
                begin
                    quarter_next = quarter_next + 2'd1;
                end
                else
                begin
                    quarter_next = 2'd0;
                    if (mode_next == MODE_START)
                    begin
                        finished = 1'b1;
                    end
                    else if (bit_next < ACK_BIT)
                    begin
                        bit_next = bit_next + 4'd1;
                    end
                    else
                    begin
                        if (mode_next == MODE_READ)
                        begin
                            sda_next = 1'b1;
                            rx_next  = shift_next;
                        end
                        finished = 1'b1;
                    end
                end
                if (finished)
                begin
                    mode_next    = MODE_IDLE;
                    quarter_next = 2'd0;
                    bit_next     = 4'd0;
                    done_next    = 1'b1;
                end
            end
            else
            begin
                div_next = div_inc[QT_W-1:0];
            end
        end
    end

    // result word from the updated state
    always_comb
    begin
        result.scl_out      = scl_next;
        result.sda_out      = sda_next;
        result.busy_res     = (mode_next != MODE_IDLE);
        result.done_res     = done_next;
        result.ack_received = ack_next;
        result.rx_byte      = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            quarter_reg  <= 2'd0;
            bit_reg      <= 4'd0;
            shift_reg    <= '0;
            div_reg      <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_reg      <= 1'b0;
            send_ack_reg <= 1'b0;
            rx_reg       <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            quarter_reg  <= quarter_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            div_reg      <= div_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_reg      <= ack_next;
            send_ack_reg <= send_ack_next;
            rx_reg       <= rx_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2cm_out_buf.sv -----
// result register with one skid entry
// depends on i2cm_pkg
`default_nettype none

module i2cm_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire i2cm_pkg::result_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output i2cm_pkg::result_t      pop_data
);
    import i2cm_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    // ready depends only on the skid flag, so no path from pop_ready
    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (main_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    main_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_data;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_reg <= push_data;
        end
    end

    assign pop_valid = main_valid_reg;
    assign pop_data  = main_reg;

endmodule

`default_nettype wire
